// ----- hw/rtl/gost_pkg.sv -----
// gost_pkg: shared constants, request codes and the s-box substitution
// used by the gost block cipher core; no dependencies
`default_nettype none

package gost_pkg;

  localparam int unsigned HalfW   = 32;
  localparam int unsigned BlockW  = 64;
  localparam int unsigned KeyNum  = 8;
  localparam int unsigned KeyIdxW = 3;
  localparam int unsigned RoundW  = 5;
  localparam int unsigned RotAmt  = 11;
  localparam int unsigned ReqW    = 2;

  typedef logic [ReqW-1:0] req_t;

  localparam req_t REQ_ENCRYPT = 2'd0;
  localparam req_t REQ_DECRYPT = 2'd1;
  localparam req_t REQ_MAC     = 2'd2;
  localparam req_t REQ_PASS    = 2'd3;

  localparam logic [RoundW-1:0] LAST_ROUND_FULL = 5'd31;
  localparam logic [RoundW-1:0] LAST_ROUND_MAC  = 5'd15;
  localparam logic [RoundW-1:0] KEY_TURN_ENC    = 5'd24;
  localparam logic [RoundW-1:0] KEY_TURN_DEC    = 5'd8;

  typedef logic [3:0] sbox_row_t [16];
  typedef sbox_row_t  sbox_rom_t [8];

  // first index is the nibble position, second the nibble value
  localparam sbox_rom_t SBOX = '{
    '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
      4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
    '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
      4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
    '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
      4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
    '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
      4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
    '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
      4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
    '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
      4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
      4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
    '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
      4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
  };

  // eight independent 4-bit lookups, one per nibble position
  function automatic logic [HalfW-1:0] sbox_sub(input logic [HalfW-1:0] x);
    logic [HalfW-1:0] y;
    y = '0;
    for (int p = 0; p < 8; p++) begin
      y[4*p +: 4] = SBOX[p][x[4*p +: 4]];
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gost_block_cipher.sv -----
// gost_block_cipher: ecb encrypt, decrypt and mac transform of one 64-bit block
// depends on gost_pkg for the s-box table and request codes
`default_nettype none

// One request carries a 64-bit block and a request type. A single round unit
// (key add, s-box layer, rotate by 11, xor) is reused once per cycle under a
// round counter, so encrypt and decrypt run 32 rounds and the mac transform
// 16 rounds; request type three skips the rounds and is ready in the cycle
// after it is accepted. The result sits in an output register until taken,
// and the next request is taken after that. The user must write the eight
// key words through the cfg port while the core is idle; it is not checked.
module gost_block_cipher (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [gost_pkg::ReqW-1:0]            req_type,
  input  wire logic [gost_pkg::BlockW-1:0]          block_in,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [gost_pkg::BlockW-1:0]               block_out,
  input  wire logic                                 cfg_we,
  input  wire logic [gost_pkg::KeyIdxW-1:0]         cfg_index,
  input  wire logic [gost_pkg::HalfW-1:0]           cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                         state, state_next;
  logic [gost_pkg::RoundW-1:0]        round, round_next;
  gost_pkg::req_t                     req;
  logic [gost_pkg::HalfW-1:0]         n1, n2;
  logic [gost_pkg::HalfW-1:0]         key [gost_pkg::KeyNum];

  logic [gost_pkg::KeyIdxW-1:0]       key_sel;
  logic [gost_pkg::HalfW-1:0]         sum, sub, rot, n1_new;
  logic                               last_round;
  logic                               in_fire, out_fire;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign block_out = {n2, n1};

  // key word order: forward, or reversed after the turn point
  always_comb begin
    unique case (req)
      gost_pkg::REQ_ENCRYPT:
        key_sel = (round < gost_pkg::KEY_TURN_ENC) ? round[2:0] : ~round[2:0];
      gost_pkg::REQ_DECRYPT:
        key_sel = (round < gost_pkg::KEY_TURN_DEC) ? round[2:0] : ~round[2:0];
      default:
        key_sel = round[2:0];
    endcase
  end

  assign last_round = (req == gost_pkg::REQ_MAC) ? (round == gost_pkg::LAST_ROUND_MAC)
                                                 : (round == gost_pkg::LAST_ROUND_FULL);

  // shared round unit
  assign sum    = n1 + key[key_sel];
  assign sub    = gost_pkg::sbox_sub(sum);
  assign rot    = {sub[gost_pkg::HalfW-gost_pkg::RotAmt-1:0],
                   sub[gost_pkg::HalfW-1:gost_pkg::HalfW-gost_pkg::RotAmt]};
  assign n1_new = rot ^ n2;

  always_comb begin
    state_next = state;
    round_next = round;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          round_next = '0;
          state_next = (req_type == gost_pkg::REQ_PASS) ? ST_OUT : ST_RUN;
        end
      end
      ST_RUN: begin
        round_next = round + 1'b1;
        if (last_round) begin
          state_next = ST_OUT;
          round_next = '0;
        end
      end
      ST_OUT: begin
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      round <= '0;
    end else begin
      state <= state_next;
      round <= round_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gost_pkg::KeyNum; i++) key[i] <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req <= req_type;
      n1  <= block_in[gost_pkg::HalfW-1:0];
      n2  <= block_in[gost_pkg::BlockW-1:gost_pkg::HalfW];
    end else if (state == ST_RUN) begin
      // final round of encrypt and decrypt leaves the halves unswapped
      if (last_round && req != gost_pkg::REQ_MAC) begin
        n1 <= n1;
        n2 <= n1_new;
      end else begin
        n1 <= n1_new;
        n2 <= n1;
      end
    end
  end

  a_ready_out_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_round_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> (round == '0))
    else $error("round counter not cleared outside a run");

  a_mac_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && req == gost_pkg::REQ_MAC) |-> (round <= gost_pkg::LAST_ROUND_MAC))
    else $error("mac transform ran past its last round");

  a_pass_direct: assert property (@(posedge clk) disable iff (rst)
    (in_fire && req_type == gost_pkg::REQ_PASS) |=> out_valid)
    else $error("pass-through request did not go straight to output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(block_out))
    else $error("result dropped or changed while stalled");

endmodule

`default_nettype wire
